>>> rtl/mvfr_pkg.sv
package mvfr_pkg;

  // fade level scale, reset values
  localparam int unsigned FullLevel = 1024;
  localparam logic [14:0] BASE_RESET = 15'h3000;
  localparam logic [14:0] MAX_VOLUME = 15'h7fff;
  localparam logic signed [11:0] LEVEL_RESET = 12'sh400;
  localparam logic [10:0] LEVEL_FULL = 11'h400;

  // shared unit sizing: 11 bit multiplier / dividend, 27 bit accumulator
  localparam int unsigned ITER = 11;
  localparam int unsigned CNT_W = $clog2(ITER);
  localparam int unsigned ACC_W = 27;

  // input opcodes
  typedef enum logic [2:0] {
    OPC_TICK     = 3'd0,
    OPC_FADE_OUT = 3'd1,
    OPC_FADE_IN  = 3'd2,
    OPC_PAUSE    = 3'd3,
    OPC_UNPAUSE  = 3'd4
  } opcode_t;

  // shared unit operation
  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> rtl/mvfr_if.sv
interface mvfr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [10:0] duration;
  logic signed [11:0] target_level;

  modport source (output valid, opcode, duration, target_level, input ready);
  modport sink (input valid, opcode, duration, target_level, output ready);
endinterface

interface mvfr_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] volume;
  logic        volume_write;
  logic        accepted;
  logic        fade_done;
  logic        fading;

  modport source (output valid, volume, volume_write, accepted, fade_done, fading,
                  input ready);
  modport sink (input valid, volume, volume_write, accepted, fade_done, fading,
                output ready);
endinterface

>>> rtl/mvfr_muldiv.sv
module mvfr_muldiv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mvfr_pkg::unit_ctl_t              ctl_i,
  input  logic [14:0]                      opnd_a_i,
  input  logic [10:0]                      opnd_b_i,
  output mvfr_pkg::unit_sts_t              sts_o,
  output logic [mvfr_pkg::ACC_W-1:0]       prod_o,
  output logic [10:0]                      quot_o
);

  logic                          busy_r;
  logic                          done_r;
  logic [mvfr_pkg::CNT_W-1:0]    cnt_r;
  mvfr_pkg::uop_t                op_r;
  logic [mvfr_pkg::ACC_W-1:0]    acc_r;
  logic [10:0]                   q_r;
  logic [14:0]                   opnd_r;

  logic [mvfr_pkg::ACC_W-1:0]    shifted;
  logic [mvfr_pkg::ACC_W-1:0]    addend;
  logic [mvfr_pkg::ACC_W-1:0]    sum;
  logic [mvfr_pkg::ACC_W-1:0]    acc_nxt;
  logic [10:0]                   q_nxt;
  logic                          is_div;

  // one shared adder: shift-add multiply or restoring divide, msb first
  always_comb begin
    is_div  = (op_r == mvfr_pkg::UOP_DIV);
    shifted = {acc_r[mvfr_pkg::ACC_W-2:0], is_div & q_r[10]};
    if (is_div) begin
      addend = ~{{(mvfr_pkg::ACC_W-15){1'b0}}, opnd_r};
    end else if (q_r[10]) begin
      addend = {{(mvfr_pkg::ACC_W-15){1'b0}}, opnd_r};
    end else begin
      addend = '0;
    end
    sum = shifted + addend + {{(mvfr_pkg::ACC_W-1){1'b0}}, is_div};
    if (is_div && sum[mvfr_pkg::ACC_W-1]) begin
      acc_nxt = shifted;
    end else begin
      acc_nxt = sum;
    end
    q_nxt = {q_r[9:0], is_div & ~sum[mvfr_pkg::ACC_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= ctl_i.op;
        opnd_r <= opnd_a_i;
        q_r    <= opnd_b_i;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + mvfr_pkg::CNT_W'(1);
        if (cnt_r == mvfr_pkg::CNT_W'(mvfr_pkg::ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign prod_o     = acc_r;
  assign quot_o     = q_r;

endmodule

>>> rtl/master_volume_fade_ramp.sv
// a tick that writes a volume or a start that is taken shows its result only after the input
//   transfer has passed through the shared multiply/divide unit (11 steps plus load and unload);
//   any other item goes from the transfer straight to the finish state and the output register
// items are taken one at a time: input ready stays low until the result is in the output register,
//   and arithmetic waits on the single shared shift-add unit; a stalled output holds the result back
// reset: synchronous active-low rst_n; level 1024, fade-in target 1024, base volume 0x3000
module master_volume_fade_ramp (
  input  logic              clk,
  input  logic              rst_n,
  mvfr_in_if.sink           in_ch,
  mvfr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [14:0]       cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_FIN
  } state_t;

  localparam logic [10:0] LEVEL_FULL_W = mvfr_pkg::LEVEL_FULL;

  state_t state_r;

  // fade state
  logic signed [11:0] fade_level_r, fade_level_nxt;
  logic [10:0]        out_step_r, out_target_r, out_target_nxt;
  logic [10:0]        in_step_r, in_target_r, in_target_nxt;
  logic               fading_down_r, fading_down_nxt;
  logic               fading_up_r, fading_up_nxt;
  logic               paused_r, paused_nxt;
  logic [14:0]        base_volume_r;

  // result being built
  logic        pend_wr_r, pend_wr_nxt;
  logic        pend_acc_r, pend_acc_nxt;
  logic        pend_done_r, pend_done_nxt;
  logic        pend_down_r, pend_down_nxt;
  mvfr_pkg::uop_t pend_op_r;
  logic [14:0] pend_vol_r;

  // output register
  logic        out_valid_r;
  logic [14:0] out_volume_r;
  logic        out_wr_r, out_acc_r, out_done_r, out_fading_r;

  // shared unit hookup
  mvfr_pkg::unit_ctl_t           unit_ctl;
  mvfr_pkg::unit_sts_t           unit_sts;
  logic [10:0]                   unit_b;
  logic [mvfr_pkg::ACC_W-1:0]    unit_prod;
  logic [10:0]                   unit_quot;

  logic               in_xfer;
  logic               out_free;
  logic [10:0]        dur_c, tgt_c;
  logic signed [11:0] mul_level;
  logic               down_req, same_dir, other_dir;
  logic [14:0]        vol_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // duration clamped to 1..1024, target to 0..1024
  always_comb begin
    if (in_ch.duration == '0) begin
      dur_c = 11'd1;
    end else if (in_ch.duration > LEVEL_FULL_W) begin
      dur_c = mvfr_pkg::LEVEL_FULL;
    end else begin
      dur_c = in_ch.duration;
    end
    if (in_ch.target_level[11]) begin
      tgt_c = '0;
    end else if (in_ch.target_level > $signed({1'b0, mvfr_pkg::LEVEL_FULL})) begin
      tgt_c = mvfr_pkg::LEVEL_FULL;
    end else begin
      tgt_c = in_ch.target_level[10:0];
    end
  end

  // item decode: all state moves at the transfer, the unit fills in volume or step
  always_comb begin
    fade_level_nxt  = fade_level_r;
    out_target_nxt  = out_target_r;
    in_target_nxt   = in_target_r;
    fading_down_nxt = fading_down_r;
    fading_up_nxt   = fading_up_r;
    paused_nxt      = paused_r;
    pend_wr_nxt     = 1'b0;
    pend_acc_nxt    = 1'b0;
    pend_done_nxt   = 1'b0;
    pend_down_nxt   = 1'b0;
    mul_level       = '0;
    unit_ctl.start  = 1'b0;
    unit_ctl.op     = mvfr_pkg::UOP_MUL;
    down_req        = (in_ch.opcode == mvfr_pkg::OPC_FADE_OUT);
    same_dir        = down_req ? fading_down_r : fading_up_r;
    other_dir       = down_req ? fading_up_r : fading_down_r;

    unique case (in_ch.opcode)
      mvfr_pkg::OPC_TICK: begin
        if (!paused_r && fading_down_r) begin
          pend_wr_nxt    = 1'b1;
          unit_ctl.start = in_xfer;
          if (fade_level_r > $signed({1'b0, out_target_r})) begin
            mul_level      = fade_level_r;
            fade_level_nxt = fade_level_r - $signed({1'b0, out_step_r});
          end else begin
            // target reached or passed: snap and finish
            mul_level       = $signed({1'b0, out_target_r});
            fade_level_nxt  = $signed({1'b0, out_target_r});
            fading_down_nxt = 1'b0;
            fading_up_nxt   = 1'b0;
            pend_done_nxt   = 1'b1;
          end
        end else if (!paused_r && fading_up_r) begin
          pend_wr_nxt    = 1'b1;
          unit_ctl.start = in_xfer;
          if (fade_level_r < $signed({1'b0, in_target_r})) begin
            mul_level      = fade_level_r;
            fade_level_nxt = fade_level_r + $signed({1'b0, in_step_r});
          end else begin
            mul_level       = $signed({1'b0, in_target_r});
            fade_level_nxt  = $signed({1'b0, in_target_r});
            fading_down_nxt = 1'b0;
            fading_up_nxt   = 1'b0;
            pend_done_nxt   = 1'b1;
          end
        end
      end
      mvfr_pkg::OPC_FADE_OUT, mvfr_pkg::OPC_FADE_IN: begin
        // a start in the running direction is refused outright
        if (!same_dir) begin
          if (other_dir) begin
            pend_done_nxt = 1'b1;
          end
          pend_acc_nxt   = 1'b1;
          pend_down_nxt  = down_req;
          unit_ctl.start = in_xfer;
          unit_ctl.op    = mvfr_pkg::UOP_DIV;
          if (down_req) begin
            out_target_nxt  = tgt_c;
            fading_down_nxt = 1'b1;
            fading_up_nxt   = 1'b0;
          end else begin
            in_target_nxt   = tgt_c;
            fading_up_nxt   = 1'b1;
            fading_down_nxt = 1'b0;
          end
        end
      end
      mvfr_pkg::OPC_PAUSE:   paused_nxt = 1'b1;
      mvfr_pkg::OPC_UNPAUSE: paused_nxt = 1'b0;
      default: ;
    endcase

    // multiplier operand is the level when positive, divisor path takes the dividend
    if (unit_ctl.op == mvfr_pkg::UOP_DIV) begin
      unit_b = mvfr_pkg::LEVEL_FULL;
    end else if (mul_level > 12'sd0) begin
      unit_b = mul_level[10:0];
    end else begin
      unit_b = '0;
    end
  end

  mvfr_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (unit_ctl),
    .opnd_a_i (unit_ctl.op == mvfr_pkg::UOP_DIV ? {4'b0, dur_c} : base_volume_r),
    .opnd_b_i (unit_b),
    .sts_o    (unit_sts),
    .prod_o   (unit_prod),
    .quot_o   (unit_quot)
  );

  // product / 1024, saturated to 15 bits
  assign vol_sat = (unit_prod[26:25] != 2'b00) ? mvfr_pkg::MAX_VOLUME : unit_prod[24:10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fade_level_r  <= mvfr_pkg::LEVEL_RESET;
      out_step_r    <= '0;
      out_target_r  <= '0;
      in_step_r     <= '0;
      in_target_r   <= mvfr_pkg::LEVEL_FULL;
      fading_down_r <= 1'b0;
      fading_up_r   <= 1'b0;
      paused_r      <= 1'b0;
      base_volume_r <= mvfr_pkg::BASE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_volume_r <= cfg_wdata;
      end
      // in the finish state the register is reloaded instead
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            fade_level_r  <= fade_level_nxt;
            out_target_r  <= out_target_nxt;
            in_target_r   <= in_target_nxt;
            fading_down_r <= fading_down_nxt;
            fading_up_r   <= fading_up_nxt;
            paused_r      <= paused_nxt;
            pend_wr_r     <= pend_wr_nxt;
            pend_acc_r    <= pend_acc_nxt;
            pend_done_r   <= pend_done_nxt;
            pend_down_r   <= pend_down_nxt;
            pend_op_r     <= unit_ctl.op;
            pend_vol_r    <= '0;
            state_r       <= unit_ctl.start ? S_BUSY : S_FIN;
          end
        end
        S_BUSY: begin
          if (unit_sts.done) begin
            if (pend_op_r == mvfr_pkg::UOP_MUL) begin
              pend_vol_r <= vol_sat;
            end else if (pend_down_r) begin
              out_step_r <= unit_quot;
            end else begin
              in_step_r <= unit_quot;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // wait for the output register to free up
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_volume_r <= pend_vol_r;
            out_wr_r     <= pend_wr_r;
            out_acc_r    <= pend_acc_r;
            out_done_r   <= pend_done_r;
            out_fading_r <= fading_down_r || fading_up_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.volume       = out_volume_r;
  assign out_ch.volume_write = out_wr_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.fade_done    = out_done_r;
  assign out_ch.fading       = out_fading_r;

  // the shared unit only runs while the sequencer waits on it
  a_unit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    unit_sts.busy |-> state_r == S_BUSY)
    else $error("arithmetic unit running outside busy state");

  // the two fade directions never run together
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    !(fading_down_r && fading_up_r))
    else $error("fade-in and fade-out both active");

  // done comes only with a volume write or a taken start
  a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.fade_done) |-> (out_ch.volume_write || out_ch.accepted))
    else $error("fade done without a cause");

  // nothing written means zero volume
  a_quiet_volume: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.volume_write) |-> out_ch.volume == '0)
    else $error("volume without a write");

endmodule
